/* hw/rtl/rri_pkg.sv */
// Shared types, constants and microcode program for the Rossler RK4 integrator.
// Depends on nothing; every other file of the block imports it.
package rri_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 24;
    localparam int STEP_W = 31;
    localparam int UPC_W  = 7;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [4:0]               src_t;
    typedef logic [2:0]               cfg_idx_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Configuration register indexes
    localparam cfg_idx_t CFG_PARAM_A   = 3'd0;
    localparam cfg_idx_t CFG_PARAM_B   = 3'd1;
    localparam cfg_idx_t CFG_PARAM_C   = 3'd2;
    localparam cfg_idx_t CFG_TIME_STEP = 3'd3;
    localparam cfg_idx_t CFG_INIT_X    = 3'd4;
    localparam cfg_idx_t CFG_INIT_Y    = 3'd5;
    localparam cfg_idx_t CFG_INIT_Z    = 3'd6;

    localparam word_t             RST_PARAM_A   = 32'sd3355443;
    localparam word_t             RST_PARAM_B   = 32'sd3355443;
    localparam word_t             RST_PARAM_C   = 32'sd95630131;
    localparam logic [STEP_W-1:0] RST_TIME_STEP = 31'd167772;
    localparam word_t             RST_INIT_X    = 32'sd1677722;
    localparam word_t             RST_INIT_Y    = 32'sd0;
    localparam word_t             RST_INIT_Z    = 32'sd0;

    // ceil(2^34 / 6): exact floor division by six for any 31-bit value
    localparam logic [31:0] RECIP6       = 32'hAAAAAAAB;
    localparam int          RECIP6_SHIFT = 34;

    // Operand / destination codes
    localparam src_t SRC_ZERO  = 5'd0;
    localparam src_t SRC_SX    = 5'd1;
    localparam src_t SRC_SY    = 5'd2;
    localparam src_t SRC_SZ    = 5'd3;
    localparam src_t SRC_TX    = 5'd4;
    localparam src_t SRC_TY    = 5'd5;
    localparam src_t SRC_TZ    = 5'd6;
    localparam src_t SRC_KX    = 5'd7;
    localparam src_t SRC_KY    = 5'd8;
    localparam src_t SRC_KZ    = 5'd9;
    localparam src_t SRC_WX    = 5'd10;
    localparam src_t SRC_WY    = 5'd11;
    localparam src_t SRC_WZ    = 5'd12;
    localparam src_t SRC_R     = 5'd13;
    localparam src_t SRC_PA    = 5'd14;
    localparam src_t SRC_PB    = 5'd15;
    localparam src_t SRC_PC    = 5'd16;
    localparam src_t SRC_HALF  = 5'd17;
    localparam src_t SRC_DT    = 5'd18;
    localparam src_t SRC_SIXTH = 5'd19;

    typedef struct packed {
        logic is_mul;
        logic neg_a;
        logic neg_b;
        src_t src_a;
        src_t src_b;
        src_t dst;
        logic done;
    } uc_word_t;

    typedef struct packed {
        logic     uop_en;
        logic     load_init;
        uc_word_t uop;
    } dp_ctl_t;

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        end
        return s[WORD_W-1:0];
    endfunction

    function automatic word_t sat_neg(input word_t a);
        if (a == WORD_MIN) begin
            return WORD_MAX;
        end
        return -a;
    endfunction

    // Fixed-point product, floor rounding, saturated to the word range
    function automatic word_t sat_mul(input word_t a, input word_t b);
        logic signed [2*WORD_W-1:0]      p;
        logic signed [2*WORD_W-FRAC_W-1:0] q;
        p = a * b;
        q = p[2*WORD_W-1:FRAC_W];
        if (q > $signed({{(WORD_W-FRAC_W){1'b0}}, WORD_MAX})) begin
            return WORD_MAX;
        end
        if (q < $signed({{(WORD_W-FRAC_W){1'b1}}, WORD_MIN})) begin
            return WORD_MIN;
        end
        return q[WORD_W-1:0];
    endfunction

    function automatic uc_word_t uw(input logic m, input logic na, input logic nb,
                                    input src_t a, input src_t b, input src_t d,
                                    input logic dn);
        uc_word_t w;
        w.is_mul = m;
        w.neg_a  = na;
        w.neg_b  = nb;
        w.src_a  = a;
        w.src_b  = b;
        w.dst    = d;
        w.done   = dn;
        return w;
    endfunction

    // One RK4 step: copy S to T, then four derivative passes (T -> K) with the
    // weighted sum in W and the probe state rebuilt in T, then S += W * dt/6.
    function automatic uc_word_t uc_fetch(input logic [UPC_W-1:0] pc);
        uc_word_t w;
        case (pc)
            7'd0:  w = uw(1'b0, 1'b0, 1'b0, SRC_SX, SRC_ZERO, SRC_TX, 1'b0);
            7'd1:  w = uw(1'b0, 1'b0, 1'b0, SRC_SY, SRC_ZERO, SRC_TY, 1'b0);
            7'd2:  w = uw(1'b0, 1'b0, 1'b0, SRC_SZ, SRC_ZERO, SRC_TZ, 1'b0);
            // derivative of T into K
            7'd3, 7'd18, 7'd36, 7'd54:
                w = uw(1'b0, 1'b1, 1'b1, SRC_TY, SRC_TZ, SRC_KX, 1'b0);
            7'd4, 7'd19, 7'd37, 7'd55:
                w = uw(1'b1, 1'b0, 1'b0, SRC_PA, SRC_TY, SRC_R, 1'b0);
            7'd5, 7'd20, 7'd38, 7'd56:
                w = uw(1'b0, 1'b0, 1'b0, SRC_TX, SRC_R, SRC_KY, 1'b0);
            7'd6, 7'd21, 7'd39, 7'd57:
                w = uw(1'b0, 1'b0, 1'b1, SRC_TX, SRC_PC, SRC_R, 1'b0);
            7'd7, 7'd22, 7'd40, 7'd58:
                w = uw(1'b1, 1'b0, 1'b0, SRC_TZ, SRC_R, SRC_R, 1'b0);
            7'd8, 7'd23, 7'd41, 7'd59:
                w = uw(1'b0, 1'b0, 1'b0, SRC_PB, SRC_R, SRC_KZ, 1'b0);
            // first weight
            7'd9:  w = uw(1'b0, 1'b0, 1'b0, SRC_KX, SRC_ZERO, SRC_WX, 1'b0);
            7'd10: w = uw(1'b0, 1'b0, 1'b0, SRC_KY, SRC_ZERO, SRC_WY, 1'b0);
            7'd11: w = uw(1'b0, 1'b0, 1'b0, SRC_KZ, SRC_ZERO, SRC_WZ, 1'b0);
            // probe state at half step, and at full step for k4
            7'd12, 7'd30: w = uw(1'b1, 1'b0, 1'b0, SRC_KX, SRC_HALF, SRC_R, 1'b0);
            7'd14, 7'd32: w = uw(1'b1, 1'b0, 1'b0, SRC_KY, SRC_HALF, SRC_R, 1'b0);
            7'd16, 7'd34: w = uw(1'b1, 1'b0, 1'b0, SRC_KZ, SRC_HALF, SRC_R, 1'b0);
            7'd48: w = uw(1'b1, 1'b0, 1'b0, SRC_KX, SRC_DT, SRC_R, 1'b0);
            7'd50: w = uw(1'b1, 1'b0, 1'b0, SRC_KY, SRC_DT, SRC_R, 1'b0);
            7'd52: w = uw(1'b1, 1'b0, 1'b0, SRC_KZ, SRC_DT, SRC_R, 1'b0);
            7'd13, 7'd31, 7'd49:
                w = uw(1'b0, 1'b0, 1'b0, SRC_SX, SRC_R, SRC_TX, 1'b0);
            7'd15, 7'd33, 7'd51:
                w = uw(1'b0, 1'b0, 1'b0, SRC_SY, SRC_R, SRC_TY, 1'b0);
            7'd17, 7'd35, 7'd53:
                w = uw(1'b0, 1'b0, 1'b0, SRC_SZ, SRC_R, SRC_TZ, 1'b0);
            // doubled weights for k2 and k3
            7'd24, 7'd42: w = uw(1'b0, 1'b0, 1'b0, SRC_KX, SRC_KX, SRC_R, 1'b0);
            7'd25, 7'd43: w = uw(1'b0, 1'b0, 1'b0, SRC_WX, SRC_R, SRC_WX, 1'b0);
            7'd26, 7'd44: w = uw(1'b0, 1'b0, 1'b0, SRC_KY, SRC_KY, SRC_R, 1'b0);
            7'd27, 7'd45: w = uw(1'b0, 1'b0, 1'b0, SRC_WY, SRC_R, SRC_WY, 1'b0);
            7'd28, 7'd46: w = uw(1'b0, 1'b0, 1'b0, SRC_KZ, SRC_KZ, SRC_R, 1'b0);
            7'd29, 7'd47: w = uw(1'b0, 1'b0, 1'b0, SRC_WZ, SRC_R, SRC_WZ, 1'b0);
            // last weight
            7'd60: w = uw(1'b0, 1'b0, 1'b0, SRC_WX, SRC_KX, SRC_WX, 1'b0);
            7'd61: w = uw(1'b0, 1'b0, 1'b0, SRC_WY, SRC_KY, SRC_WY, 1'b0);
            7'd62: w = uw(1'b0, 1'b0, 1'b0, SRC_WZ, SRC_KZ, SRC_WZ, 1'b0);
            // state update
            7'd63: w = uw(1'b1, 1'b0, 1'b0, SRC_WX, SRC_SIXTH, SRC_R, 1'b0);
            7'd64: w = uw(1'b0, 1'b0, 1'b0, SRC_SX, SRC_R, SRC_SX, 1'b0);
            7'd65: w = uw(1'b1, 1'b0, 1'b0, SRC_WY, SRC_SIXTH, SRC_R, 1'b0);
            7'd66: w = uw(1'b0, 1'b0, 1'b0, SRC_SY, SRC_R, SRC_SY, 1'b0);
            7'd67: w = uw(1'b1, 1'b0, 1'b0, SRC_WZ, SRC_SIXTH, SRC_R, 1'b0);
            7'd68: w = uw(1'b0, 1'b0, 1'b0, SRC_SZ, SRC_R, SRC_SZ, 1'b1);
            default: w = uw(1'b0, 1'b0, 1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b1);
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/rossler_rk4_integrator_top.sv */
// Rossler attractor integrator, classic RK4 at a fixed step, Q8.24 arithmetic.
// An advance transfer adds its elapsed time (clipped to MAX_STEPS steps) to a
// time accumulator; while a whole step is held the block runs one RK4 step
// and delivers x, y, z, with m_last on the final result of the transfer. A
// restart transfer reloads init_x/y/z, clears the accumulator and delivers
// that state once. Each RK4 step is a 69-instruction microprogram executed
// one instruction per cycle on a single saturating add / multiply unit,
// with the accumulator check before it and the result load after it as
// handoff. s_ready stays low from a transfer until its last result is
// loaded, also while a result waits for m_ready in the full result
// register; an advance with no step holds it low for the check alone.
// The step rate is bound by the sequential dependency through the shared
// multiplier. A result register separates the output side: the next
// transfer is accepted while a delivered result still waits for m_ready.
// Depends on rri_pkg, rri_sequencer and rri_datapath.
module rossler_rk4_integrator_top #(
    parameter int MAX_STEPS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration writes
    input  logic                        cfg_we,
    input  rri_pkg::cfg_idx_t           cfg_index,
    input  logic [31:0]                 cfg_wdata,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic signed [31:0]          s_elapsed,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_pos_x,
    output logic signed [31:0]          m_pos_y,
    output logic signed [31:0]          m_pos_z,
    output logic                        m_last
);
    import rri_pkg::*;

    word_t             param_a_reg, param_b_reg, param_c_reg;
    word_t             init_x_reg, init_y_reg, init_z_reg;
    logic [STEP_W-1:0] time_step_reg, step_eff;

    word_t   cur_x, cur_y, cur_z;
    dp_ctl_t ctl;
    logic    out_free, out_load, out_last;

    logic    m_valid_reg, m_last_reg;
    word_t   pos_x_reg, pos_y_reg, pos_z_reg;

    // A zero step acts as one LSB
    assign step_eff = (time_step_reg == '0) ? STEP_W'(1) : time_step_reg;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            param_a_reg   <= RST_PARAM_A;
            param_b_reg   <= RST_PARAM_B;
            param_c_reg   <= RST_PARAM_C;
            time_step_reg <= RST_TIME_STEP;
            init_x_reg    <= RST_INIT_X;
            init_y_reg    <= RST_INIT_Y;
            init_z_reg    <= RST_INIT_Z;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PARAM_A:   param_a_reg   <= cfg_wdata;
                CFG_PARAM_B:   param_b_reg   <= cfg_wdata;
                CFG_PARAM_C:   param_c_reg   <= cfg_wdata;
                CFG_TIME_STEP: time_step_reg <= cfg_wdata[STEP_W-1:0];
                CFG_INIT_X:    init_x_reg    <= cfg_wdata;
                CFG_INIT_Y:    init_y_reg    <= cfg_wdata;
                CFG_INIT_Z:    init_z_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rri_sequencer #(
        .MAX_STEPS (MAX_STEPS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_elapsed (s_elapsed),
        .step_eff  (step_eff),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_last  (out_last),
        .ctl       (ctl)
    );

    rri_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .param_a  (param_a_reg),
        .param_b  (param_b_reg),
        .param_c  (param_c_reg),
        .step_eff (step_eff),
        .init_x   (init_x_reg),
        .init_y   (init_y_reg),
        .init_z   (init_z_reg),
        .cur_x    (cur_x),
        .cur_y    (cur_y),
        .cur_z    (cur_z)
    );

    // Output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until the transfer completes
    always_ff @(posedge aclk) begin
        if (out_load) begin
            pos_x_reg  <= cur_x;
            pos_y_reg  <= cur_y;
            pos_z_reg  <= cur_z;
            m_last_reg <= out_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pos_x = pos_x_reg;
    assign m_pos_y = pos_y_reg;
    assign m_pos_z = pos_z_reg;
    assign m_last  = m_last_reg;

`ifndef NO_ASSERTIONS
    // The microprogram never runs while the input side is open
    a_no_run_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && ctl.uop_en))
        else $error("microcode active while accepting input");

    // A restart always leads to a delivery before the next transfer is taken
    a_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op) |=> !s_ready)
        else $error("restart did not block input");

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten");
`endif

endmodule

/* hw/rtl/rri_datapath.sv */
// Register file and shared saturating add / multiply unit driven by microcode.
// Depends on rri_pkg.
module rri_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rri_pkg::dp_ctl_t              ctl,
    input  rri_pkg::word_t                param_a,
    input  rri_pkg::word_t                param_b,
    input  rri_pkg::word_t                param_c,
    input  logic [rri_pkg::STEP_W-1:0]    step_eff,
    input  rri_pkg::word_t                init_x,
    input  rri_pkg::word_t                init_y,
    input  rri_pkg::word_t                init_z,
    output rri_pkg::word_t                cur_x,
    output rri_pkg::word_t                cur_y,
    output rri_pkg::word_t                cur_z
);
    import rri_pkg::*;

    word_t sx_reg, sy_reg, sz_reg, tx_reg, ty_reg, tz_reg;
    word_t kx_reg, ky_reg, kz_reg, wx_reg, wy_reg, wz_reg, r_reg;
    logic [STEP_W-3:0] sixth_reg;
    logic [STEP_W+31:0] sixth_prod;
    word_t va, vb, oa, ob, res;

    function automatic word_t pick(input src_t s);
        word_t v;
        case (s)
            SRC_ZERO:  v = '0;
            SRC_SX:    v = sx_reg;
            SRC_SY:    v = sy_reg;
            SRC_SZ:    v = sz_reg;
            SRC_TX:    v = tx_reg;
            SRC_TY:    v = ty_reg;
            SRC_TZ:    v = tz_reg;
            SRC_KX:    v = kx_reg;
            SRC_KY:    v = ky_reg;
            SRC_KZ:    v = kz_reg;
            SRC_WX:    v = wx_reg;
            SRC_WY:    v = wy_reg;
            SRC_WZ:    v = wz_reg;
            SRC_R:     v = r_reg;
            SRC_PA:    v = param_a;
            SRC_PB:    v = param_b;
            SRC_PC:    v = param_c;
            SRC_HALF:  v = word_t'({2'b00, step_eff[STEP_W-1:1]});
            SRC_DT:    v = word_t'({1'b0, step_eff});
            SRC_SIXTH: v = word_t'({3'b000, sixth_reg});
            default:   v = '0;
        endcase
        return v;
    endfunction

    assign sixth_prod = {32'd0, step_eff} * {{STEP_W{1'b0}}, RECIP6};

    always_comb begin
        va  = pick(ctl.uop.src_a);
        vb  = pick(ctl.uop.src_b);
        oa  = ctl.uop.neg_a ? sat_neg(va) : va;
        ob  = ctl.uop.neg_b ? sat_neg(vb) : vb;
        res = ctl.uop.is_mul ? sat_mul(oa, ob) : sat_add(oa, ob);
    end

    // dt / 6 follows the step register; it settles long before any step runs
    always_ff @(posedge aclk) begin
        sixth_reg <= sixth_prod[RECIP6_SHIFT+STEP_W-3:RECIP6_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg <= RST_INIT_X;
            sy_reg <= RST_INIT_Y;
            sz_reg <= RST_INIT_Z;
        end else if (ctl.load_init) begin
            sx_reg <= init_x;
            sy_reg <= init_y;
            sz_reg <= init_z;
        end else if (ctl.uop_en) begin
            if (ctl.uop.dst == SRC_SX) sx_reg <= res;
            if (ctl.uop.dst == SRC_SY) sy_reg <= res;
            if (ctl.uop.dst == SRC_SZ) sz_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.uop_en) begin
            case (ctl.uop.dst)
                SRC_TX:  tx_reg <= res;
                SRC_TY:  ty_reg <= res;
                SRC_TZ:  tz_reg <= res;
                SRC_KX:  kx_reg <= res;
                SRC_KY:  ky_reg <= res;
                SRC_KZ:  kz_reg <= res;
                SRC_WX:  wx_reg <= res;
                SRC_WY:  wy_reg <= res;
                SRC_WZ:  wz_reg <= res;
                SRC_R:   r_reg  <= res;
                default: ;
            endcase
        end
    end

    assign cur_x = sx_reg;
    assign cur_y = sy_reg;
    assign cur_z = sz_reg;

endmodule

/* hw/rtl/rri_sequencer.sv */
// Step counter, microcode fetch and time accumulator control.
// Depends on rri_pkg.
module rri_sequencer #(
    parameter int MAX_STEPS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  rri_pkg::word_t                s_elapsed,
    input  logic [rri_pkg::STEP_W-1:0]    step_eff,
    input  logic                          out_free,
    output logic                          out_load,
    output logic                          out_last,
    output rri_pkg::dp_ctl_t              ctl
);
    import rri_pkg::*;

    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int CAP_W = STEP_W + CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_PUT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] accum_reg, accum_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [UPC_W-1:0]  upc_reg, upc_next;
    logic              last_reg, last_next;

    logic [CAP_W-1:0]  cap, e_pos, e_clip;
    logic [CAP_W:0]    sum;
    logic [STEP_W-1:0] accum_sub;
    uc_word_t          uop;

    assign uop       = uc_fetch(upc_reg);
    assign cap       = CAP_W'(step_eff) * CAP_W'(MAX_STEPS);
    assign e_pos     = CAP_W'(s_elapsed[WORD_W-2:0]);
    assign e_clip    = (e_pos > cap) ? cap : e_pos;
    assign sum       = (CAP_W+1)'(accum_reg) + (CAP_W+1)'(e_clip);
    assign accum_sub = accum_reg - step_eff;

    always_comb begin
        state_next    = state_reg;
        accum_next    = accum_reg;
        n_next        = n_reg;
        upc_next      = upc_reg;
        last_next     = last_reg;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        ctl.uop_en    = 1'b0;
        ctl.load_init = 1'b0;
        ctl.uop       = uop;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op) begin
                        ctl.load_init = 1'b1;
                        accum_next    = '0;
                        last_next     = 1'b1;
                        state_next    = ST_PUT;
                    end else if (!s_elapsed[WORD_W-1] && (s_elapsed != '0)) begin
                        accum_next = (sum > (CAP_W+1)'({STEP_W{1'b1}})) ?
                                     {STEP_W{1'b1}} : sum[STEP_W-1:0];
                        n_next     = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if ((n_reg < CNT_W'(MAX_STEPS)) && (accum_reg >= step_eff)) begin
                    upc_next   = '0;
                    state_next = ST_RUN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN: begin
                ctl.uop_en = 1'b1;
                upc_next   = upc_reg + 1'b1;
                if (uop.done) begin
                    accum_next = accum_sub;
                    n_next     = n_reg + 1'b1;
                    last_next  = (n_reg + 1'b1 == CNT_W'(MAX_STEPS)) ||
                                 (accum_sub < step_eff);
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = last_reg ? ST_IDLE : ST_CHECK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_last = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            accum_reg <= '0;
            n_reg     <= '0;
            upc_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            accum_reg <= accum_next;
            n_reg     <= n_next;
            upc_reg   <= upc_next;
            last_reg  <= last_next;
        end
    end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for rossler_rk4_integrator_top: random and directed
// advance/restart transfers checked against an in-bench RK4 predictor.
// Depends on rri_pkg and the integrator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rri_pkg::*;

    localparam bit       OP_ADVANCE = 1'b0;
    localparam bit       OP_RESTART = 1'b1;
    localparam cfg_idx_t CFG_NONE   = 3'd7;   // past the register list
    localparam int       STEPS_CAP  = 16;
    localparam int       IDLE_LIMIT = 20000;
    localparam int       LONG_HOLD  = 3000;
    localparam int       SETTLE     = 200;

    typedef struct {
        logic [31:0] x, y, z;
        bit          last;
    } traj_point_t;

    // Predicts trajectory points and matches them against delivered results.
    class rossler_scoreboard;
        traj_point_t  pending[$];
        int           errors;
        longint       cx, cy, cz, accum;
        logic [31:0]  regs[7];

        function void power_on();
            regs[CFG_PARAM_A]   = RST_PARAM_A;
            regs[CFG_PARAM_B]   = RST_PARAM_B;
            regs[CFG_PARAM_C]   = RST_PARAM_C;
            regs[CFG_TIME_STEP] = {1'b0, RST_TIME_STEP};
            regs[CFG_INIT_X]    = RST_INIT_X;
            regs[CFG_INIT_Y]    = RST_INIT_Y;
            regs[CFG_INIT_Z]    = RST_INIT_Z;
            reload();
        endfunction

        function void reload();
            cx = rword(CFG_INIT_X);
            cy = rword(CFG_INIT_Y);
            cz = rword(CFG_INIT_Z);
            accum = 0;
        endfunction

        function longint rword(int i);
            return longint'(signed'(regs[i]));
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] val);
            if (idx > CFG_INIT_Z) return;
            regs[idx] = (idx == CFG_TIME_STEP) ? {1'b0, val[30:0]} : val;
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint addw(longint a, longint b);
            return clip(a + b);
        endfunction

        function longint mulw(longint a, longint b);
            return clip((a * b) >>> FRAC_W);
        endfunction

        function void slope(longint sx, longint sy, longint sz,
                            output longint dx, output longint dy, output longint dz);
            dx = addw(clip(-sy), clip(-sz));
            dy = addw(sx, mulw(rword(CFG_PARAM_A), sy));
            dz = addw(rword(CFG_PARAM_B),
                      mulw(sz, addw(sx, clip(-rword(CFG_PARAM_C)))));
        endfunction

        function void rk4_step(longint dt);
            longint k1[3], k2[3], k3[3], k4[3], s[3], w;
            longint half, sixth;
            half = dt >>> 1;
            sixth = dt / 6;
            s[0] = cx; s[1] = cy; s[2] = cz;
            slope(s[0], s[1], s[2], k1[0], k1[1], k1[2]);
            slope(addw(s[0], mulw(k1[0], half)), addw(s[1], mulw(k1[1], half)),
                  addw(s[2], mulw(k1[2], half)), k2[0], k2[1], k2[2]);
            slope(addw(s[0], mulw(k2[0], half)), addw(s[1], mulw(k2[1], half)),
                  addw(s[2], mulw(k2[2], half)), k3[0], k3[1], k3[2]);
            slope(addw(s[0], mulw(k3[0], dt)), addw(s[1], mulw(k3[1], dt)),
                  addw(s[2], mulw(k3[2], dt)), k4[0], k4[1], k4[2]);
            for (int i = 0; i < 3; i++) begin
                w = addw(k1[i], addw(k2[i], k2[i]));
                w = addw(w, addw(k3[i], k3[i]));
                w = addw(w, k4[i]);
                s[i] = addw(s[i], mulw(w, sixth));
            end
            cx = s[0]; cy = s[1]; cz = s[2];
        endfunction

        function void push_point(bit last);
            traj_point_t p;
            p.x = cx[31:0]; p.y = cy[31:0]; p.z = cz[31:0]; p.last = last;
            pending.push_back(p);
        endfunction

        function void note_input(bit op, logic [31:0] elapsed);
            longint el, step;
            int n;
            if (op == OP_RESTART) begin
                reload();
                push_point(1);
                return;
            end
            el = longint'(signed'(elapsed));
            if (el <= 0) return;
            step = regs[CFG_TIME_STEP];
            if (step == 0) step = 1;
            if (el > step * STEPS_CAP) el = step * STEPS_CAP;
            accum = addw(accum, clip(el));
            n = 0;
            while (n < STEPS_CAP && accum >= step) begin
                rk4_step(step);
                accum -= step;
                n++;
                push_point(0);
            end
            if (n > 0) pending[$].last = 1;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
            traj_point_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result x=%h y=%h z=%h", x, y, z));
                return;
            end
            e = pending.pop_front();
            if (x !== e.x) report($sformatf("pos_x %h, want %h", x, e.x));
            if (y !== e.y) report($sformatf("pos_y %h, want %h", y, e.y));
            if (z !== e.z) report($sformatf("pos_z %h, want %h", z, e.z));
            if (last !== e.last) report($sformatf("last %0b, want %0b", last, e.last));
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    cfg_idx_t          cfg_index = '0;
    logic [31:0]       cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_op = 1'b0;
    logic signed [31:0] s_elapsed = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_pos_z;
    logic              m_last;

    rossler_scoreboard sb = new();
    bit  hold_req = 0;     // sender asks the receiver for one long hold-off
    int  idle_cycles = 0;
    int  burst_left = 0;

    rossler_rk4_integrator_top uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Sample both channels at the rising edge; results first, since a result
    // transferred at the same edge as a new item belongs to older work.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check(m_pos_x, m_pos_y, m_pos_z, m_last);
            if (s_valid && s_ready) sb.note_input(s_op, s_elapsed);
        end
    end

    // Watchdog: count cycles in which neither channel moves a transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: the stall mode is redrawn at random from four patterns; a
    // requested long hold-off is counted down here, independent of the sender.
    int rx_cycle = 0;
    int hold_cnt = 0;
    int rx_mode = 0;
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = LONG_HOLD;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ((rx_cycle % 8) < 5);
            endcase
        end
    end

    // Offer one item and hold it until it transfers.
    task send(bit op, logic [31:0] el);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_elapsed <= el;
        do @(posedge aclk); while (!s_ready);
    endtask

    task drop_valid(int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Send with burst/gap pacing.
    task send_paced(bit op, logic [31:0] el);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) drop_valid($urandom_range(1, 8));
        end
        burst_left--;
        send(op, el);
    endtask

    // Hold until every expected result is in, then let the block settle.
    task drain();
        drop_valid(1);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task cfg_write(cfg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
    endtask

    task cfg_end();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function logic [31:0] rand_elapsed(longint step);
        longint top;
        int pick;
        pick = $urandom_range(0, 19);
        top = step * 4;
        if (top > 64'h7FFF_FFFF) top = 64'h7FFF_FFFF;
        if (pick == 0) return 32'(-$signed($urandom_range(0, 32'h7FFF_FFFF)));
        if (pick == 1) return '0;
        if (pick <= 3) return $urandom();
        return $urandom_range(1, 32'(top));
    endfunction

    initial begin
        longint st;
        sb.power_on();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with reset settings.
        st = RST_TIME_STEP;
        send(OP_RESTART, 32'h0);
        send(OP_ADVANCE, 32'(st));
        send(OP_ADVANCE, 32'(st - 1));     // below one step: nothing
        send(OP_ADVANCE, 32'd1);           // completes the step
        send(OP_ADVANCE, 32'd0);
        send(OP_ADVANCE, 32'hFFFF_FFFF);
        send(OP_ADVANCE, 32'h8000_0000);
        send(OP_ADVANCE, 32'h7FFF_FFFF);   // clipped to the step cap
        send(OP_ADVANCE, 32'(st / 2));
        send(OP_ADVANCE, 32'(st * 17));    // leftover stays in the accumulator
        send(OP_ADVANCE, 32'(st / 2));
        send(OP_RESTART, 32'hFFFF_FFFF);
        drain();

        // Extreme coefficients, zero step read as one LSB, saturated start.
        cfg_write(CFG_PARAM_A, 32'h7FFF_FFFF);
        cfg_write(CFG_PARAM_B, 32'h8000_0000);
        cfg_write(CFG_PARAM_C, 32'h8000_0000);
        cfg_write(CFG_TIME_STEP, 32'h8000_0000);
        cfg_write(CFG_INIT_X, 32'h7FFF_FFFF);
        cfg_write(CFG_INIT_Y, 32'h8000_0000);
        cfg_write(CFG_INIT_Z, 32'h7FFF_FFFF);
        cfg_write(CFG_NONE, 32'h1234_5678);
        cfg_end();
        send(OP_ADVANCE, 32'd3);           // new init not yet in effect
        send(OP_RESTART, 32'h0);
        send(OP_ADVANCE, 32'd1);
        send(OP_ADVANCE, 32'd40);
        drain();

        // Longest step: the cap exceeds the word and the accumulator saturates.
        cfg_write(CFG_TIME_STEP, 32'h7FFF_FFFF);
        cfg_write(CFG_PARAM_A, 32'h8000_0000);
        cfg_write(CFG_PARAM_C, 32'h7FFF_FFFF);
        cfg_end();
        send(OP_ADVANCE, 32'h7FFF_FFFF);
        send(OP_ADVANCE, 32'h7FFF_FFFF);
        send(OP_RESTART, 32'h0);
        drain();

        // Random phases, each under its own settings.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                cfg_write(CFG_PARAM_A, RST_PARAM_A);
                cfg_write(CFG_PARAM_B, RST_PARAM_B);
                cfg_write(CFG_PARAM_C, RST_PARAM_C);
                cfg_write(CFG_TIME_STEP, {1'b0, RST_TIME_STEP});
            end else begin
                cfg_write(CFG_PARAM_A, ph % 2 ? $urandom() : $urandom_range(0, 1 << 25));
                cfg_write(CFG_PARAM_B, $urandom());
                cfg_write(CFG_PARAM_C, ph % 2 ? $urandom() : $urandom_range(0, 1 << 27));
                cfg_write(CFG_TIME_STEP, ph == 1 ? 32'd1 :
                          ph == 2 ? 32'hFFFF_FFFF : $urandom_range(1000, 1 << 22));
            end
            cfg_write(CFG_INIT_X, ph % 2 ? $urandom() : $urandom_range(0, 1 << 26));
            cfg_write(CFG_INIT_Y, ph % 2 ? $urandom() : $urandom_range(0, 1 << 26));
            cfg_write(CFG_INIT_Z, ph % 2 ? $urandom() : $urandom_range(0, 1 << 26));
            cfg_end();
            st = sb.regs[CFG_TIME_STEP];
            if (st == 0) st = 1;
            send_paced(OP_RESTART, $urandom());
            for (int i = 0; i < 70; i++) begin
                // Back up results with a long receiver hold while still sending.
                if (ph == 3 && i == 10) hold_req = 1;
                if (ph == 3 && i >= 10 && i < 20) send(OP_ADVANCE, 32'(st * 3));
                else if ($urandom_range(0, 9) == 0) send_paced(OP_RESTART, $urandom());
                else send_paced(OP_ADVANCE, rand_elapsed(st));
            end
            drain();
        end

        if (sb.pending.size() != 0) sb.report("results never delivered");
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
